FILE: sv/phnt_pkg.sv
// Package for the perfect and harmonic divisor number test.
// Holds field widths, the sequencer state type and the structs between modules.
// No dependencies.
package phnt_pkg;

  localparam int NUM_W  = 16;  // input number width
  localparam int CNT_W  = 8;   // divisor count width
  localparam int SUM_W  = 18;  // proper divisor sum width
  localparam int SIG_W  = 19;  // sigma(n) width, which can pass 2^18 near the top of the range
  localparam int DVD_W  = 24;  // widest dividend handled by the remainder unit
  localparam int STEP_W = 5;   // enough bits to hold DVD_W steps

  localparam logic [STEP_W-1:0] TRIAL_STEPS = STEP_W'(NUM_W);
  localparam logic [STEP_W-1:0] HARM_STEPS  = STEP_W'(DVD_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIAL_CHECK,
    ST_TRIAL_WAIT,
    ST_MUL,
    ST_HARM_ISSUE,
    ST_HARM_WAIT,
    ST_DONE
  } phnt_state_t;

  // Request to the shared remainder unit. The dividend is left aligned and
  // steps gives how many of its upper bits are consumed.
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [SIG_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } phnt_rem_req_t;

  typedef struct packed {
    logic             done;
    logic [SIG_W-1:0] remainder;
  } phnt_rem_rsp_t;

  // One finished result from the sequencer.
  typedef struct packed {
    logic             rejected;
    logic [CNT_W-1:0] divisor_count;
    logic [SUM_W-1:0] proper_divisor_sum;
    logic             is_perfect;
    logic             is_harmonic;
  } phnt_result_t;

endpackage

FILE: sv/phnt_if.sv
// Valid/ready channel interfaces for the input number and the result.
// Depends on phnt_pkg for field widths.
interface phnt_in_if;
  logic                       valid;
  logic                       ready;
  logic [phnt_pkg::NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface phnt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       rejected;
  logic [phnt_pkg::CNT_W-1:0] divisor_count;
  logic [phnt_pkg::SUM_W-1:0] proper_divisor_sum;
  logic                       is_perfect;
  logic                       is_harmonic;

  modport source (output valid, output rejected, output divisor_count,
                  output proper_divisor_sum, output is_perfect, output is_harmonic,
                  input ready);
  modport sink   (input valid, input rejected, input divisor_count,
                  input proper_divisor_sum, input is_perfect, input is_harmonic,
                  output ready);
endinterface

FILE: sv/phnt_rem_unit.sv
// Shared radix-2 restoring remainder unit, one quotient bit per cycle.
// Depends on phnt_pkg for the request and response structs.
module phnt_rem_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  phnt_pkg::phnt_rem_req_t req,
  output phnt_pkg::phnt_rem_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [phnt_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [phnt_pkg::DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [phnt_pkg::SIG_W-1:0]     dvs_r, dvs_nxt;
  logic [phnt_pkg::SIG_W-1:0]     rem_r, rem_nxt;
  logic [phnt_pkg::SIG_W:0]       shifted;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    shifted  = {rem_r, dvd_r[phnt_pkg::DVD_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so one subtract suffices.
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = phnt_pkg::SIG_W'(shifted - {1'b0, dvs_r});
      end else begin
        rem_nxt = shifted[phnt_pkg::SIG_W-1:0];
      end
      dvd_nxt = {dvd_r[phnt_pkg::DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - phnt_pkg::STEP_W'(1);
      if (cnt_r == phnt_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: sv/phnt_core.sv
// Sequencer and accumulators for the divisor test; drives the shared remainder unit.
// Depends on phnt_pkg and phnt_rem_unit.
module phnt_core #(
  parameter int NUMBER_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [phnt_pkg::NUM_W-1:0] in_number,
  output logic                       res_valid,
  input  logic                       res_take,
  output phnt_pkg::phnt_result_t     res
);

  localparam int EFF_BITS = (NUMBER_BITS < phnt_pkg::NUM_W) ? NUMBER_BITS : phnt_pkg::NUM_W;
  localparam logic [phnt_pkg::NUM_W-1:0] NUM_MASK =
    phnt_pkg::NUM_W'((33'd1 << EFF_BITS) - 33'd1);

  phnt_pkg::phnt_state_t       state_r, state_nxt;
  logic [phnt_pkg::NUM_W-1:0]  n_r, n_nxt;
  logic [phnt_pkg::NUM_W-1:0]  i_r, i_nxt;
  logic [phnt_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [phnt_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [phnt_pkg::DVD_W-1:0]  prod_r, prod_nxt;
  logic [phnt_pkg::SIG_W-1:0]  sigma_r, sigma_nxt;
  logic                        rej_r, rej_nxt;
  logic                        perf_r, perf_nxt;
  logic                        harm_r, harm_nxt;
  logic [phnt_pkg::NUM_W-1:0]  masked;
  phnt_pkg::phnt_rem_req_t     req;
  phnt_pkg::phnt_rem_rsp_t     rsp;

  phnt_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    sigma_nxt = sigma_r;
    rej_nxt   = rej_r;
    perf_nxt  = perf_r;
    harm_nxt  = harm_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    masked    = in_number & NUM_MASK;
    req       = '0;
    case (state_r)
      phnt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (masked == '0) begin
            rej_nxt   = 1'b1;
            state_nxt = phnt_pkg::ST_DONE;
          end else begin
            rej_nxt   = 1'b0;
            n_nxt     = masked;
            i_nxt     = phnt_pkg::NUM_W'(1);
            sum_nxt   = '0;
            cnt_nxt   = phnt_pkg::CNT_W'(1);
            state_nxt = phnt_pkg::ST_TRIAL_CHECK;
          end
        end
      end
      phnt_pkg::ST_TRIAL_CHECK: begin
        if (i_r <= {1'b0, n_r[phnt_pkg::NUM_W-1:1]}) begin
          req.start    = 1'b1;
          req.dividend = {n_r, {(phnt_pkg::DVD_W-phnt_pkg::NUM_W){1'b0}}};
          req.divisor  = phnt_pkg::SIG_W'(i_r);
          req.steps    = phnt_pkg::TRIAL_STEPS;
          state_nxt    = phnt_pkg::ST_TRIAL_WAIT;
        end else begin
          state_nxt = phnt_pkg::ST_MUL;
        end
      end
      phnt_pkg::ST_TRIAL_WAIT: begin
        if (rsp.done) begin
          if (rsp.remainder == '0) begin
            sum_nxt = sum_r + phnt_pkg::SUM_W'(i_r);
            cnt_nxt = cnt_r + phnt_pkg::CNT_W'(1);
          end
          i_nxt     = i_r + phnt_pkg::NUM_W'(1);
          state_nxt = phnt_pkg::ST_TRIAL_CHECK;
        end
      end
      phnt_pkg::ST_MUL: begin
        prod_nxt  = phnt_pkg::DVD_W'(n_r) * phnt_pkg::DVD_W'(cnt_r);
        sigma_nxt = phnt_pkg::SIG_W'(sum_r) + phnt_pkg::SIG_W'(n_r);
        perf_nxt  = (sum_r == phnt_pkg::SUM_W'(n_r));
        state_nxt = phnt_pkg::ST_HARM_ISSUE;
      end
      phnt_pkg::ST_HARM_ISSUE: begin
        req.start    = 1'b1;
        req.dividend = prod_r;
        req.divisor  = sigma_r;
        req.steps    = phnt_pkg::HARM_STEPS;
        state_nxt    = phnt_pkg::ST_HARM_WAIT;
      end
      phnt_pkg::ST_HARM_WAIT: begin
        if (rsp.done) begin
          harm_nxt  = (rsp.remainder == '0);
          state_nxt = phnt_pkg::ST_DONE;
        end
      end
      phnt_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = phnt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = phnt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= phnt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    sum_r   <= sum_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
    sigma_r <= sigma_nxt;
    rej_r   <= rej_nxt;
    perf_r  <= perf_nxt;
    harm_r  <= harm_nxt;
  end

  // A rejected zero reports nothing but the reject flag.
  assign res.rejected           = rej_r;
  assign res.divisor_count      = rej_r ? '0 : cnt_r;
  assign res.proper_divisor_sum = rej_r ? '0 : sum_r;
  assign res.is_perfect         = rej_r ? 1'b0 : perf_r;
  assign res.is_harmonic        = rej_r ? 1'b0 : harm_r;

endmodule

FILE: sv/perfect_harmonic_number_test.sv
// Top level of the perfect and harmonic divisor number test.
// Depends on phnt_pkg, phnt_if (channel interfaces) and phnt_core.
//
// Each input transaction carries one number n; only its low NUMBER_BITS bits
// (at most 16) are used. The block tries every candidate i from 1 to n/2 one
// at a time on a shared radix-2 remainder unit, counting the divisors (n itself
// included) and summing the proper divisors. It then forms n times the count and
// sigma(n) = proper sum + n, and runs one more remainder on the same unit to see
// whether the harmonic mean of the divisors is an integer. n is perfect when the
// proper sum equals n. A zero input produces one result with only the rejected
// flag set. For a nonzero n, each trial divisor passes through a check state,
// sixteen remainder steps and a wait for the done strobe on the single
// remainder unit, and the harmonic test adds a multiply state and twenty-four
// remainder steps. The input is ready only while the sequencer is idle.
// Results go through an output register, so a new number is accepted while
// the previous result still waits to be taken.
module perfect_harmonic_number_test #(
  parameter int NUMBER_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  phnt_in_if.sink    in_chan,
  phnt_out_if.source out_chan
);

  logic                   res_valid;
  logic                   res_take;
  phnt_pkg::phnt_result_t res;

  logic                   out_valid_r, out_valid_nxt;
  phnt_pkg::phnt_result_t out_data_r, out_data_nxt;

  phnt_core #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_number (in_chan.number),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // The core hands over its result whenever the output register is empty or is
  // being emptied in this same cycle.
  assign res_take = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.rejected           = out_data_r.rejected;
  assign out_chan.divisor_count      = out_data_r.divisor_count;
  assign out_chan.proper_divisor_sum = out_data_r.proper_divisor_sum;
  assign out_chan.is_perfect         = out_data_r.is_perfect;
  assign out_chan.is_harmonic        = out_data_r.is_harmonic;

endmodule
